// File: hdl/polar_angle_point_sorter_assert.svh
// ----------------------------------------------------------------------------
// polar angle point sorter assertion macros
// concurrent checks sampled on the rising clock edge, held off during reset
// ----------------------------------------------------------------------------
`ifndef POLAR_ANGLE_POINT_SORTER_ASSERT_SVH
`define POLAR_ANGLE_POINT_SORTER_ASSERT_SVH

// same-cycle implication
`define PAS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("polar_angle_point_sorter: same-cycle check failed");

// next-cycle implication
`define PAS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("polar_angle_point_sorter: next-cycle check failed");

`endif

// File: hdl/pas_pkg.sv
// ----------------------------------------------------------------------------
// pas_pkg
// shared types and register indexes of the polar angle point sorter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pas_pkg;

  // configuration register indexes
  localparam logic CFG_ANCHOR_X = 1'b0;
  localparam logic CFG_ANCHOR_Y = 1'b1;

  // controls broadcast to every cell of the chain
  typedef struct packed {
    logic calc;    // register the angle products against the new point
    logic insert;  // open a slot and shift the tail down by one
    logic pop;     // move every entry one cell towards the head
  } cell_ctrl_t;

endpackage

// File: hdl/pas_cell.sv
// ----------------------------------------------------------------------------
// pas_cell
// one slot of the insertion chain: holds a point, compares it to the new one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pas_cell #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pas_pkg::cell_ctrl_t            ctrl,
  input  logic signed [COORD_BITS-1:0]   anchor_x,
  input  logic signed [COORD_BITS-1:0]   anchor_y,
  input  logic signed [COORD_BITS:0]     bdx,
  input  logic signed [COORD_BITS:0]     bdy,
  input  logic        [2*COORD_BITS:0]   lb,
  input  logic signed [COORD_BITS-1:0]   new_x,
  input  logic signed [COORD_BITS-1:0]   new_y,
  input  logic signed [COORD_BITS-1:0]   prv_x,
  input  logic signed [COORD_BITS-1:0]   prv_y,
  input  logic                           prv_vld,
  input  logic signed [COORD_BITS-1:0]   nxt_x,
  input  logic signed [COORD_BITS-1:0]   nxt_y,
  input  logic                           nxt_vld,
  input  logic                           seen_prev,
  input  logic                           seen_here,
  output logic signed [COORD_BITS-1:0]   x,
  output logic signed [COORD_BITS-1:0]   y,
  output logic                           vld,
  output logic                           ahead
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int LW = 2 * COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] x_r;
  logic signed [COORD_BITS-1:0] y_r;
  logic                         vld_r;
  logic signed [DW-1:0]         adx_r;
  logic signed [DW-1:0]         ady_r;
  logic signed [PW-1:0]         p1_r;
  logic signed [PW-1:0]         p2_r;
  logic        [LW-1:0]         la_r;

  logic signed [DW-1:0]         adx;
  logic signed [DW-1:0]         ady;
  logic signed [PW-1:0]         sqx;
  logic signed [PW-1:0]         sqy;
  logic signed [PW:0]           turn;
  logic                         same_x;
  logic                         same_y;

  assign adx = {x_r[COORD_BITS-1], x_r} - {anchor_x[COORD_BITS-1], anchor_x};
  assign ady = {y_r[COORD_BITS-1], y_r} - {anchor_y[COORD_BITS-1], anchor_y};
  assign sqx = adx * adx;
  assign sqy = ady * ady;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctrl.pop) begin
      vld_r <= nxt_vld;
    end else if (ctrl.insert && seen_here) begin
      vld_r <= seen_prev ? prv_vld : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      x_r <= nxt_x;
      y_r <= nxt_y;
    end else if (ctrl.insert && seen_here) begin
      x_r <= seen_prev ? prv_x : new_x;
      y_r <= seen_prev ? prv_y : new_y;
    end
    if (ctrl.calc) begin
      adx_r <= adx;
      ady_r <= ady;
      p1_r  <= adx * bdy;
      p2_r  <= bdx * ady;
      la_r  <= {1'b0, sqx[LW-2:0]} + {1'b0, sqy[LW-2:0]};
    end
  end

  assign turn   = {p1_r[PW-1], p1_r} - {p2_r[PW-1], p2_r};
  assign same_x = (adx_r == '0) || (bdx == '0) || (adx_r[DW-1] == bdx[DW-1]);
  assign same_y = (ady_r == '0) || (bdy == '0) || (ady_r[DW-1] == bdy[DW-1]);

  always_comb begin
    if (turn[PW]) begin
      ahead = 1'b1;
    end else if (turn != '0) begin
      ahead = 1'b0;
    end else if (same_x && same_y) begin
      ahead = lb < la_r;
    end else begin
      // opposite sides: the stored point goes last unless right of or above the anchor
      ahead = (adx_r[DW-1] || adx_r == '0) && (ady_r[DW-1] || ady_r == '0);
    end
  end

  assign x   = x_r;
  assign y   = y_r;
  assign vld = vld_r;

endmodule

// File: hdl/polar_angle_point_sorter.sv
// ----------------------------------------------------------------------------
// polar_angle_point_sorter
// sorts a batch of points by polar angle about a programmable anchor
// ----------------------------------------------------------------------------
// Points arrive one beat each on the in_ channel (valid/stall); the beat with
// in_batch_end set closes the batch. Each point is placed in a chain of
// MAX_POINTS cells that keeps the batch in order: first the angle products
// are registered in every cell, then a slot is opened at the insertion point
// and the tail is shifted down. An input beat therefore occupies the block
// until its slot is open, and no new point is taken before then; in_stall is
// high while a point is being placed or a batch is being sent.
// After the closing beat the chain drains through cell 0 on the out_ channel,
// one result beat per cycle unless out_stall holds the chain and the current
// beat, starting once the closing point is placed. out_run_end marks the last
// beat, out_overflowed is set on every beat of a batch that lost points
// because the chain was full. The user must write the anchor through cfg_ only
// while no batch is being sent; the block does not enforce it. Reset empties
// the chain, clears the overflow flag and sets the anchor to the origin.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polar_angle_point_sorter #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic                         in_batch_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_sorted_x,
  output logic signed [COORD_BITS-1:0] out_sorted_y,
  output logic                         out_run_end,
  output logic                         out_overflowed
);

  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int LW  = 2 * COORD_BITS + 1;
  localparam int LVL = $clog2(MAX_POINTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_INS  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]                   state_r;
  logic                         drop_r;
  logic signed [COORD_BITS-1:0] anchor_x_r;
  logic signed [COORD_BITS-1:0] anchor_y_r;
  logic signed [COORD_BITS-1:0] px_r;
  logic signed [COORD_BITS-1:0] py_r;
  logic                         end_r;
  logic signed [DW-1:0]         bdx_r;
  logic signed [DW-1:0]         bdy_r;
  logic        [LW-1:0]         lb_r;

  logic signed [PW-1:0]         sqx;
  logic signed [PW-1:0]         sqy;
  pas_pkg::cell_ctrl_t          ctrl;
  logic                         full;

  logic signed [COORD_BITS-1:0] cx     [MAX_POINTS];
  logic signed [COORD_BITS-1:0] cy     [MAX_POINTS];
  logic [MAX_POINTS-1:0]        cvld;
  logic [MAX_POINTS-1:0]        cbefore;
  logic [MAX_POINTS-1:0]        eff;
  logic [MAX_POINTS-1:0]        seen;
  logic [MAX_POINTS-1:0]        pfx    [LVL+1];

  // anchor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_x_r <= '0;
      anchor_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pas_pkg::CFG_ANCHOR_X: anchor_x_r <= cfg_wdata;
        pas_pkg::CFG_ANCHOR_Y: anchor_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign full     = cvld[MAX_POINTS-1];
  assign in_stall = (state_r != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      drop_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_INS;
        end
        S_INS: begin
          if (full) begin
            drop_r <= 1'b1;
          end
          state_r <= end_r ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!out_stall && out_run_end) begin
            drop_r  <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign sqx = bdx_r * bdx_r;
  assign sqy = bdy_r * bdy_r;

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      px_r  <= in_point_x;
      py_r  <= in_point_y;
      end_r <= in_batch_end;
      bdx_r <= {in_point_x[COORD_BITS-1], in_point_x} - {anchor_x_r[COORD_BITS-1], anchor_x_r};
      bdy_r <= {in_point_y[COORD_BITS-1], in_point_y} - {anchor_y_r[COORD_BITS-1], anchor_y_r};
    end
    if (state_r == S_MUL) begin
      lb_r <= {1'b0, sqx[LW-2:0]} + {1'b0, sqy[LW-2:0]};
    end
  end

  always_comb begin
    ctrl        = '0;
    ctrl.calc   = (state_r == S_MUL);
    ctrl.insert = (state_r == S_INS) && !full;
    ctrl.pop    = out_valid && !out_stall;
  end

  // empty cells always take the new point, so the first hit marks the slot
  assign eff = ~cvld | cbefore;

  // prefix or over the hit vector, log depth
  always_comb begin
    pfx[0] = eff;
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        if (i >= (1 << l)) begin
          pfx[l+1][i] = pfx[l][i] | pfx[l][i - (1 << l)];
        end else begin
          pfx[l+1][i] = pfx[l][i];
        end
      end
    end
    seen = pfx[LVL];
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic signed [COORD_BITS-1:0] prv_x;
    logic signed [COORD_BITS-1:0] prv_y;
    logic                         prv_vld;
    logic                         seen_prev;
    logic signed [COORD_BITS-1:0] nxt_x;
    logic signed [COORD_BITS-1:0] nxt_y;
    logic                         nxt_vld;

    if (i == 0) begin : g_head
      assign prv_x     = '0;
      assign prv_y     = '0;
      assign prv_vld   = 1'b0;
      assign seen_prev = 1'b0;
    end else begin : g_body
      assign prv_x     = cx[i-1];
      assign prv_y     = cy[i-1];
      assign prv_vld   = cvld[i-1];
      assign seen_prev = seen[i-1];
    end

    if (i == MAX_POINTS - 1) begin : g_tail
      assign nxt_x   = '0;
      assign nxt_y   = '0;
      assign nxt_vld = 1'b0;
    end else begin : g_link
      assign nxt_x   = cx[i+1];
      assign nxt_y   = cy[i+1];
      assign nxt_vld = cvld[i+1];
    end

    pas_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .anchor_x  (anchor_x_r),
      .anchor_y  (anchor_y_r),
      .bdx       (bdx_r),
      .bdy       (bdy_r),
      .lb        (lb_r),
      .new_x     (px_r),
      .new_y     (py_r),
      .prv_x     (prv_x),
      .prv_y     (prv_y),
      .prv_vld   (prv_vld),
      .nxt_x     (nxt_x),
      .nxt_y     (nxt_y),
      .nxt_vld   (nxt_vld),
      .seen_prev (seen_prev),
      .seen_here (seen[i]),
      .x         (cx[i]),
      .y         (cy[i]),
      .vld       (cvld[i]),
      .ahead     (cbefore[i])
    );
  end

  // results leave from the head cell
  assign out_valid      = (state_r == S_EMIT) && cvld[0];
  assign out_sorted_x   = cx[0];
  assign out_sorted_y   = cy[0];
  assign out_run_end    = !cvld[1];
  assign out_overflowed = drop_r;

`include "polar_angle_point_sorter_assert.svh"

  // occupied cells form an unbroken run from the head
  `PAS_ASSERT_IMP(a_chain_packed, clk, rst_n, 1'b1, (cvld[MAX_POINTS-1:1] & ~cvld[MAX_POINTS-2:0]) == '0)
  // a placed point adds exactly one occupied cell
  `PAS_ASSERT_NXT(a_insert_grows, clk, rst_n, ctrl.insert, $countones(cvld) == $past($countones(cvld)) + 1)
  // a batch keeps sending until its closing beat
  `PAS_ASSERT_NXT(a_drain_runs, clk, rst_n, out_valid && !out_stall && !out_run_end, out_valid)
  // the overflow flag only rises when the chain was full
  `PAS_ASSERT_NXT(a_drop_cause, clk, rst_n, state_r == S_INS && !full, drop_r == $past(drop_r))

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the polar angle point sorter: an in-bench chain
// predictor orders each batch about the anchor, and every sorted beat is
// compared field by field while both channels idle and stall at random
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int CB         = 16;
  localparam int MAX_PTS    = 64;
  localparam int QUIET_MAX  = 4000;
  localparam int SETTLE_CYC = 8;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   closing;
  } point_beat_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   run_end;
    logic   overflowed;
  } sorted_beat_t;

  logic   clk          = 1'b0;
  logic   rst_n        = 1'b0;
  logic   cfg_we       = 1'b0;
  logic   cfg_index    = pas_pkg::CFG_ANCHOR_X;
  coord_t cfg_wdata    = '0;
  logic   in_valid     = 1'b0;
  logic   in_stall;
  coord_t in_point_x   = '0;
  coord_t in_point_y   = '0;
  logic   in_batch_end = 1'b0;
  logic   out_valid;
  logic   out_stall    = 1'b0;
  coord_t out_sorted_x;
  coord_t out_sorted_y;
  logic   out_run_end;
  logic   out_overflowed;

  polar_angle_point_sorter #(
    .MAX_POINTS(MAX_PTS),
    .COORD_BITS(CB)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_batch_end  (in_batch_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sorted_x  (out_sorted_x),
    .out_sorted_y  (out_sorted_y),
    .out_run_end   (out_run_end),
    .out_overflowed(out_overflowed)
  );

  point_beat_t  pending_points[$];
  sorted_beat_t expected_sorted[$];

  // predictor copy of the chain and the anchor
  coord_t chain_x[MAX_PTS];
  coord_t chain_y[MAX_PTS];
  int     chain_len     = 0;
  logic   chain_dropped = 1'b0;
  coord_t pivot_x       = '0;
  coord_t pivot_y       = '0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;

  int mismatches       = 0;
  int beats_checked    = 0;
  int points_taken     = 0;
  int batches_closed   = 0;
  int overflow_batches = 0;
  int anchor_writes    = 0;

  coord_t prev_x = '0;
  coord_t prev_y = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  // true when the incoming point b must sit ahead of chain entry a
  function automatic bit goes_ahead(input coord_t bx, input coord_t by,
                                    input coord_t ax, input coord_t ay);
    longint adx, ady, bdx, bdy, turn, dist_a, dist_b;
    adx  = longint'(ax) - longint'(pivot_x);
    ady  = longint'(ay) - longint'(pivot_y);
    bdx  = longint'(bx) - longint'(pivot_x);
    bdy  = longint'(by) - longint'(pivot_y);
    turn = adx * bdy - bdx * ady;
    if (turn > 0) return 1'b0;
    if (turn < 0) return 1'b1;
    if (adx * bdx >= 0 && ady * bdy >= 0) begin
      dist_a = adx * adx + ady * ady;
      dist_b = bdx * bdx + bdy * bdy;
      return dist_b < dist_a;
    end
    // collinear on opposite sides: the entry goes last unless right of or above
    return (ay <= pivot_y) && (ax <= pivot_x);
  endfunction

  function automatic void place_point(input coord_t px, input coord_t py,
                                      input logic closing);
    int slot;
    sorted_beat_t res;
    if (chain_len < MAX_PTS) begin
      slot = chain_len;
      for (int i = 0; i < chain_len; i++) begin
        if (goes_ahead(px, py, chain_x[i], chain_y[i])) begin
          slot = i;
          break;
        end
      end
      for (int i = chain_len; i > slot; i--) begin
        chain_x[i] = chain_x[i-1];
        chain_y[i] = chain_y[i-1];
      end
      chain_x[slot] = px;
      chain_y[slot] = py;
      chain_len++;
    end else begin
      chain_dropped = 1'b1;
    end
    if (closing) begin
      for (int i = 0; i < chain_len; i++) begin
        res.x          = chain_x[i];
        res.y          = chain_y[i];
        res.run_end    = (i == chain_len - 1);
        res.overflowed = chain_dropped;
        expected_sorted.push_back(res);
      end
      batches_closed++;
      if (chain_dropped) overflow_batches++;
      chain_len     = 0;
      chain_dropped = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // input driver
  always @(posedge clk) begin : drive_points
    point_beat_t beat;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        beat = pending_points.pop_front();
        in_valid     <= 1'b1;
        in_point_x   <= beat.x;
        in_point_y   <= beat.y;
        in_batch_end <= beat.closing;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : drive_stall
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // monitor: predict on accepted points, check accepted sorted beats
  always @(posedge clk) begin : watch_beats
    sorted_beat_t want;
    logic moved;
    if (rst_n) begin
      moved = cfg_we;
      if (in_valid && !in_stall) begin
        place_point(in_point_x, in_point_y, in_batch_end);
        points_taken++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (expected_sorted.size() == 0) begin
          report_mismatch("unexpected sorted beat, x", out_sorted_x, 0);
        end else begin
          moved = 1'b1;
          want = expected_sorted.pop_front();
          beats_checked++;
          if (out_sorted_x !== want.x)
            report_mismatch("sorted_x", out_sorted_x, want.x);
          if (out_sorted_y !== want.y)
            report_mismatch("sorted_y", out_sorted_y, want.y);
          if (out_run_end !== want.run_end)
            report_mismatch("run_end", out_run_end, want.run_end);
          if (out_overflowed !== want.overflowed)
            report_mismatch("overflowed", out_overflowed, want.overflowed);
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_MAX) @(posedge clk);
    $display("no beat moved for %0d cycles, %0d sorted beats outstanding",
             QUIET_MAX, expected_sorted.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic add_point(input int x, input int y, input logic closing);
    point_beat_t beat;
    beat.x       = coord_t'(x);
    beat.y       = coord_t'(y);
    beat.closing = closing;
    pending_points.push_back(beat);
  endtask

  // wait until the sender is empty and every sorted beat is back, then settle
  task automatic wait_drain();
    do @(negedge clk);
    while (pending_points.size() != 0 || in_valid || expected_sorted.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_anchor(input int ax, input int ay);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= pas_pkg::CFG_ANCHOR_X;
    cfg_wdata <= coord_t'(ax);
    @(posedge clk);
    cfg_index <= pas_pkg::CFG_ANCHOR_Y;
    cfg_wdata <= coord_t'(ay);
    @(posedge clk);
    cfg_we    <= 1'b0;
    pivot_x = coord_t'(ax);
    pivot_y = coord_t'(ay);
    anchor_writes += 2;
  endtask

  // mix of wide random points, points on lines through the anchor,
  // small points near the origin and repeats
  task automatic pick_point(output coord_t x, output coord_t y);
    int mode, dx, dy, k;
    mode = $urandom_range(9);
    if (mode < 4) begin
      x = coord_t'($urandom);
      y = coord_t'($urandom);
    end else if (mode < 8) begin
      dx = $urandom_range(6);
      dy = $urandom_range(6);
      k  = $urandom_range(80);
      dx -= 3;
      dy -= 3;
      k  -= 40;
      x = coord_t'(int'(pivot_x) + k * dx);
      y = coord_t'(int'(pivot_y) + k * dy);
    end else if (mode == 8) begin
      x = coord_t'($urandom_range(16)) - coord_t'(8);
      y = coord_t'($urandom_range(16)) - coord_t'(8);
    end else begin
      x = prev_x;
      y = prev_y;
    end
    prev_x = x;
    prev_y = y;
  endtask

  task automatic push_batch(input int n);
    coord_t x, y;
    for (int i = 0; i < n; i++) begin
      pick_point(x, y);
      add_point(x, y, i == n - 1);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_p, input int ax,
                           input int ay, input int budget, input int big_batch);
    int sent, n;
    wait_drain();
    write_anchor(ax, ay);
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    sent = 0;
    while (sent < budget) begin
      n = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 2);
      push_batch(n);
      sent += n;
      // sender holds off after the first batch until it has come back
      if (sent == n) wait_drain();
    end
    if (big_batch > 0) push_batch(big_batch);
  endtask

  initial begin : sequencer
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset anchor at the origin: axis extremes, corners, collinear runs on
    // both sides, the anchor itself and a repeated point
    add_point(32767, 0, 1'b0);
    add_point(0, 32767, 1'b0);
    add_point(-32768, 0, 1'b0);
    add_point(0, -32768, 1'b0);
    add_point(32767, 32767, 1'b0);
    add_point(-32768, -32768, 1'b0);
    add_point(1, 1, 1'b0);
    add_point(3, 3, 1'b0);
    add_point(-5, -5, 1'b0);
    add_point(0, 0, 1'b0);
    add_point(1, 1, 1'b0);
    add_point(-1, 1, 1'b0);
    add_point(1, -1, 1'b1);
    wait_drain();

    // anchor in a far corner, single point batch
    write_anchor(-32768, 32767);
    add_point(32767, -32768, 1'b1);
    wait_drain();

    write_anchor(32767, -32768);
    add_point(-32768, 32767, 1'b0);
    add_point(32767, 32767, 1'b0);
    add_point(-32768, -32768, 1'b0);
    add_point(32767, -32768, 1'b0);
    add_point(0, 0, 1'b1);
    wait_drain();

    // anchor moved while a batch is half stored
    add_point(10, 10, 1'b0);
    add_point(-10, 20, 1'b0);
    wait_drain();
    write_anchor(100, -100);
    add_point(100, 50, 1'b0);
    add_point(-50, -100, 1'b0);
    add_point(300, -300, 1'b1);

    // random phases, the first ending in an overflowing batch that fills the
    // chain and whose closing point is dropped
    run_phase(0, 0, 0, 0, 12, 66);
    run_phase(47, 0, $urandom_range(65535) - 32768, $urandom_range(65535) - 32768, 12, 0);
    run_phase(0, 47, 32767, 32767, 12, 0);
    run_phase(9, 9, -32768, -32768, 12, 0);
    run_phase(0, 0, $urandom_range(200) - 100, $urandom_range(200) - 100, 10, 0);
    wait_drain();

    $display("%0d points in %0d batches, %0d sorted beats checked", points_taken,
             batches_closed, beats_checked);
    $display("%0d batches overflowed, %0d anchor writes, %0d mismatches",
             overflow_batches, anchor_writes, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: polar_angle_point_sorter.f
+incdir+hdl
hdl/pas_pkg.sv
hdl/pas_cell.sv
hdl/polar_angle_point_sorter.sv
tb/sv/tb.sv
